// File: src/ball_collision_physics_step_unit_macros.svh
// assertion helpers for the ball physics step unit
`ifndef BALL_COLLISION_PHYSICS_STEP_UNIT_MACROS_SVH
`define BALL_COLLISION_PHYSICS_STEP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BCPS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bcps check failed");
`define BCPS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bcps check failed");
`else
`define BCPS_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define BCPS_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: src/bcps_pkg.sv
`timescale 1ns / 1ps
package bcps_pkg;
  localparam int VALUE_WIDTH_DEF = 20;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int NORM_FRAC = 14;
  localparam int STEP_FRAC = 16;
  localparam int NORM_W    = 17;
  localparam int DAMP_Q16  = 58982;
  localparam int GRAV_Q16  = 642253;

  localparam int NORMAL_W = 48;
  localparam int NCOMP_W  = 16;
  localparam int OFFSET_W = 20;
  localparam int CENTER_W = 60;
  localparam int CCOMP_W  = 20;
  localparam int RADIUS_W = 19;
  localparam int STEP_W   = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_NORMAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BALL_RADIUS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd5;

  localparam logic [NORMAL_W-1:0] NORMAL_RST = 48'd16384;
  localparam logic [RADIUS_W-1:0] SRAD_RST   = 19'd2560;
  localparam logic [RADIUS_W-1:0] BRAD_RST   = 19'd256;
  localparam logic [STEP_W-1:0]   STEP_RST   = 16'd1092;
endpackage

// File: src/bcps_isqrt.sv
`timescale 1ns / 1ps
module bcps_isqrt #(
  parameter int W = 58
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   op,
  output logic           done,
  output logic [W/2-1:0] root
);
  logic [W-1:0] rem_r, res_r, bit_r, trial;
  logic         busy_r, ge;

  assign trial = res_r + bit_r;
  assign ge    = (rem_r >= trial);
  assign done  = busy_r && (bit_r == '0);
  assign root  = res_r[W/2-1:0];

  // one result bit per cycle, digit by digit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      rem_r  <= op;
      res_r  <= '0;
      bit_r  <= W'(1) << (W - 2);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (bit_r != '0) begin
        if (ge) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end
endmodule

// File: src/bcps_div.sv
`timescale 1ns / 1ps
module bcps_div #(
  parameter int W = 43
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);

  logic [W:0]    rem_r, shifted;
  logic [W-1:0]  quo_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, ge;

  assign shifted = {rem_r[W-1:0], quo_r[W-1]};
  assign ge      = (shifted >= {1'b0, den_r});
  assign done    = busy_r && (cnt_r == CW'(W));
  assign quo     = quo_r;

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      rem_r  <= '0;
      quo_r  <= num;
      den_r  <= den;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (cnt_r != CW'(W)) begin
        rem_r <= ge ? (shifted - {1'b0, den_r}) : shifted;
        quo_r <= {quo_r[W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end
endmodule

// File: src/ball_collision_physics_step_unit.sv
`timescale 1ns / 1ps
// Advances one ball by one time step per tick request, or loads its position and velocity
// on a load request. All arithmetic runs through one shared signed multiplier under a small
// sequencer, plus a bit-serial square root and a bit-serial divider for the shell normal.
// The block takes one request at a time. A plane contact adds a correction pass, and a
// shell contact adds the square root and three divisions plus a correction pass. Operands
// are OPW = max(VALUE_WIDTH, 20) + 8 bits wide. The result register lets the next request
// in while a finished result waits.
`include "ball_collision_physics_step_unit_macros.svh"
module ball_collision_physics_step_unit #(
  parameter int VALUE_WIDTH = bcps_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = bcps_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic signed [VALUE_WIDTH-1:0]      in_load_pos_x,
  input  logic signed [VALUE_WIDTH-1:0]      in_load_pos_y,
  input  logic signed [VALUE_WIDTH-1:0]      in_load_pos_z,
  input  logic signed [VALUE_WIDTH-1:0]      in_load_vel_x,
  input  logic signed [VALUE_WIDTH-1:0]      in_load_vel_y,
  input  logic signed [VALUE_WIDTH-1:0]      in_load_vel_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [VALUE_WIDTH-1:0]      out_pos_x,
  output logic signed [VALUE_WIDTH-1:0]      out_pos_y,
  output logic signed [VALUE_WIDTH-1:0]      out_pos_z,
  output logic signed [VALUE_WIDTH-1:0]      out_vel_x,
  output logic signed [VALUE_WIDTH-1:0]      out_vel_y,
  output logic signed [VALUE_WIDTH-1:0]      out_vel_z,
  output logic                               out_hit_plane,
  output logic                               out_hit_shell,
  output logic                               out_saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bcps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam int OPW   = ((VALUE_WIDTH > 20) ? VALUE_WIDTH : 20) + 8;
  localparam int ACC_W = 2 * OPW + 2;
  localparam int RT_W  = ACC_W / 2;
  localparam int DIV_W = OPW + bcps_pkg::NORM_FRAC + 1;
  localparam int NW    = bcps_pkg::NORM_W;
  localparam int NF    = bcps_pkg::NORM_FRAC;
  localparam int SF    = bcps_pkg::STEP_FRAC;
  localparam int GSH   = 32 - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] VHI = $signed((ACC_W'(1) << (VALUE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] VLO = -VHI - 1;

  localparam logic [1:0] K_LAST = 2'd2;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PD_M  = 5'd1;
  localparam logic [4:0] S_PD_A  = 5'd2;
  localparam logic [4:0] S_PD_F  = 5'd3;
  localparam logic [4:0] S_PP_M  = 5'd4;
  localparam logic [4:0] S_PP_A  = 5'd5;
  localparam logic [4:0] S_RD_M  = 5'd6;
  localparam logic [4:0] S_RD_A  = 5'd7;
  localparam logic [4:0] S_RW_M1 = 5'd8;
  localparam logic [4:0] S_RW_A1 = 5'd9;
  localparam logic [4:0] S_RW_M2 = 5'd10;
  localparam logic [4:0] S_RW_A2 = 5'd11;
  localparam logic [4:0] S_SC    = 5'd12;
  localparam logic [4:0] S_SS_M  = 5'd13;
  localparam logic [4:0] S_SS_A  = 5'd14;
  localparam logic [4:0] S_SV_M  = 5'd15;
  localparam logic [4:0] S_SV_A  = 5'd16;
  localparam logic [4:0] S_TT_M  = 5'd17;
  localparam logic [4:0] S_TT_F  = 5'd18;
  localparam logic [4:0] S_SQ    = 5'd19;
  localparam logic [4:0] S_DV_S  = 5'd20;
  localparam logic [4:0] S_DV_W  = 5'd21;
  localparam logic [4:0] S_GR_M  = 5'd22;
  localparam logic [4:0] S_GR_A  = 5'd23;
  localparam logic [4:0] S_PI_M  = 5'd24;
  localparam logic [4:0] S_PI_A  = 5'd25;
  localparam logic [4:0] S_DONE  = 5'd26;

  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] x,
                                                  input int s);
    logic signed [ACC_W-1:0] y;
    y = x + $signed(ACC_W'(1) << (s - 1));
    return y >>> s;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] clampv(input logic signed [ACC_W-1:0] x);
    if (x > VHI) return VHI[VALUE_WIDTH-1:0];
    if (x < VLO) return VLO[VALUE_WIDTH-1:0];
    return x[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic ovf(input logic signed [ACC_W-1:0] x);
    return (x > VHI) || (x < VLO);
  endfunction

  logic [4:0] state_r;
  logic [1:0] k_r;
  logic       shell_r, hp_r, hs_r, sat_r;

  logic [bcps_pkg::NORMAL_W-1:0]        normal_r;
  logic signed [bcps_pkg::OFFSET_W-1:0] offset_r;
  logic [bcps_pkg::CENTER_W-1:0]        center_r;
  logic [bcps_pkg::RADIUS_W-1:0]        srad_r, brad_r;
  logic [bcps_pkg::STEP_W-1:0]          step_r;

  logic signed [VALUE_WIDTH-1:0] p_r [3];
  logic signed [VALUE_WIDTH-1:0] v_r [3];
  logic signed [NW-1:0]          nv_r [3];
  logic signed [OPW-1:0]         c_r [3];

  logic signed [ACC_W-1:0]   acc_r, cv_r;
  logic signed [2*OPW-1:0]   prod_r;
  logic signed [OPW-1:0]     e_r, dv2_r, w_r;
  logic [RT_W-1:0]           dist_r;

  logic                          out_valid_r, hp_o_r, hs_o_r, sat_o_r;
  logic signed [VALUE_WIDTH-1:0] po_r [3];
  logic signed [VALUE_WIDTH-1:0] vo_r [3];

  logic signed [OPW-1:0]   mul_a, mul_b;
  logic signed [ACC_W-1:0] prod_x, acc_sum, r14, r16, rg, racc14, d_w, br_x, sr_x;
  logic signed [ACC_W-1:0] pk_x, vk_x, pp_sum, pi_sum, w_val, vg_val;
  logic signed [bcps_pkg::RADIUS_W:0] t_w;
  logic                    shell_go, k_last;
  logic [OPW-1:0]          cmag;
  logic                    sq_done, div_start, div_done;
  logic [RT_W-1:0]         sq_root;
  logic [DIV_W-1:0]        div_num, div_den, div_quo;
  logic signed [NW-1:0]    q_s;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_pos_x = po_r[0];
  assign out_pos_y = po_r[1];
  assign out_pos_z = po_r[2];
  assign out_vel_x = vo_r[0];
  assign out_vel_y = vo_r[1];
  assign out_vel_z = vo_r[2];
  assign out_hit_plane = hp_o_r;
  assign out_hit_shell = hs_o_r;
  assign out_saturated = sat_o_r;

  assign k_last  = (k_r == K_LAST);
  assign prod_x  = ACC_W'(prod_r);
  assign acc_sum = acc_r + prod_x;
  assign r14     = rnd(prod_x, NF);
  assign r16     = rnd(prod_x, SF);
  assign rg      = rnd(prod_x, GSH);
  assign racc14  = rnd(acc_sum, NF);
  assign br_x    = $signed(ACC_W'(brad_r));
  assign sr_x    = $signed(ACC_W'(srad_r));
  assign d_w     = rnd(acc_r, NF) - ACC_W'(offset_r);
  assign pk_x    = ACC_W'(p_r[k_r]);
  assign vk_x    = ACC_W'(v_r[k_r]);
  assign pp_sum  = pk_x + r14;
  assign pi_sum  = pk_x + r16;
  assign w_val   = vk_x - r14;
  assign vg_val  = ACC_W'(v_r[2]) - rg;
  assign t_w     = $signed({1'b0, srad_r}) - $signed({1'b0, brad_r});
  assign cmag    = c_r[k_r][OPW-1] ? OPW'(-c_r[k_r]) : OPW'(c_r[k_r]);
  assign q_s     = $signed(div_quo[NW-1:0]);

  // shell contact: off-centre, beyond the inner radius and moving outward
  assign shell_go = (acc_r != '0) && (t_w[bcps_pkg::RADIUS_W] || (acc_r > prod_x))
                    && (cv_r < 0);

  assign div_start = (state_r == S_DV_S);
  assign div_num   = (DIV_W'(cmag) << NF) + DIV_W'(dist_r >> 1);
  assign div_den   = DIV_W'(dist_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_PD_M: begin
        mul_a = OPW'(nv_r[k_r]);
        mul_b = OPW'(p_r[k_r]);
      end
      S_PP_M: begin
        mul_a = e_r;
        mul_b = OPW'(nv_r[k_r]);
      end
      S_RD_M: begin
        mul_a = OPW'(nv_r[k_r]);
        mul_b = OPW'(v_r[k_r]);
      end
      S_RW_M1: begin
        mul_a = dv2_r;
        mul_b = OPW'(nv_r[k_r]);
      end
      S_RW_M2: begin
        mul_a = w_r;
        mul_b = OPW'(bcps_pkg::DAMP_Q16);
      end
      S_SS_M: begin
        mul_a = c_r[k_r];
        mul_b = c_r[k_r];
      end
      S_SV_M: begin
        mul_a = c_r[k_r];
        mul_b = OPW'(v_r[k_r]);
      end
      S_TT_M: begin
        mul_a = OPW'(t_w);
        mul_b = OPW'(t_w);
      end
      S_GR_M: begin
        mul_a = OPW'(bcps_pkg::GRAV_Q16);
        mul_b = OPW'(step_r);
      end
      S_PI_M: begin
        mul_a = OPW'(v_r[k_r]);
        mul_b = OPW'(step_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  bcps_isqrt #(.W(ACC_W)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == S_TT_F) && shell_go),
    .op    (acc_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  bcps_div #(.W(DIV_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      shell_r     <= 1'b0;
      hp_r        <= 1'b0;
      hs_r        <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      normal_r    <= bcps_pkg::NORMAL_RST;
      offset_r    <= '0;
      center_r    <= '0;
      srad_r      <= bcps_pkg::SRAD_RST;
      brad_r      <= bcps_pkg::BRAD_RST;
      step_r      <= bcps_pkg::STEP_RST;
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= '0;
        v_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          bcps_pkg::CFG_PLANE_NORMAL:  normal_r <= cfg_data[bcps_pkg::NORMAL_W-1:0];
          bcps_pkg::CFG_PLANE_OFFSET:  offset_r <= $signed(cfg_data[bcps_pkg::OFFSET_W-1:0]);
          bcps_pkg::CFG_STATIC_CENTER: center_r <= cfg_data[bcps_pkg::CENTER_W-1:0];
          bcps_pkg::CFG_STATIC_RADIUS: srad_r   <= cfg_data[bcps_pkg::RADIUS_W-1:0];
          bcps_pkg::CFG_BALL_RADIUS:   brad_r   <= cfg_data[bcps_pkg::RADIUS_W-1:0];
          bcps_pkg::CFG_TIME_STEP:     step_r   <= cfg_data[bcps_pkg::STEP_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && (state_r != S_DONE)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            hp_r    <= 1'b0;
            hs_r    <= 1'b0;
            sat_r   <= 1'b0;
            shell_r <= 1'b0;
            k_r     <= '0;
            acc_r   <= '0;
            if (in_kind) begin
              p_r[0]  <= in_load_pos_x;
              p_r[1]  <= in_load_pos_y;
              p_r[2]  <= in_load_pos_z;
              v_r[0]  <= in_load_vel_x;
              v_r[1]  <= in_load_vel_y;
              v_r[2]  <= in_load_vel_z;
              state_r <= S_DONE;
            end else begin
              for (int i = 0; i < 3; i++) begin
                nv_r[i] <= NW'($signed(normal_r[bcps_pkg::NCOMP_W*i +: bcps_pkg::NCOMP_W]));
              end
              state_r <= S_PD_M;
            end
          end
        end
        S_PD_M: state_r <= S_PD_A;
        S_PD_A: begin
          acc_r <= acc_sum;
          if (k_last) begin
            k_r     <= '0;
            state_r <= S_PD_F;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PD_M;
          end
        end
        S_PD_F: begin
          if (d_w < br_x) begin
            hp_r    <= 1'b1;
            e_r     <= OPW'(br_x - d_w);
            state_r <= S_PP_M;
          end else begin
            state_r <= S_SC;
          end
        end
        S_PP_M: state_r <= S_PP_A;
        S_PP_A: begin
          p_r[k_r] <= clampv(pp_sum);
          if (ovf(pp_sum)) sat_r <= 1'b1;
          if (k_last) begin
            k_r     <= '0;
            acc_r   <= '0;
            state_r <= S_RD_M;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PP_M;
          end
        end
        S_RD_M: state_r <= S_RD_A;
        S_RD_A: begin
          acc_r <= acc_sum;
          if (k_last) begin
            dv2_r   <= OPW'(racc14 <<< 1);
            k_r     <= '0;
            state_r <= S_RW_M1;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_RD_M;
          end
        end
        S_RW_M1: state_r <= S_RW_A1;
        S_RW_A1: begin
          w_r     <= OPW'(w_val);
          state_r <= S_RW_M2;
        end
        S_RW_M2: state_r <= S_RW_A2;
        S_RW_A2: begin
          v_r[k_r] <= clampv(r16);
          if (ovf(r16)) sat_r <= 1'b1;
          if (k_last) begin
            k_r     <= '0;
            state_r <= shell_r ? S_GR_M : S_SC;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_RW_M1;
          end
        end
        S_SC: begin
          for (int i = 0; i < 3; i++) begin
            c_r[i] <= OPW'($signed(center_r[bcps_pkg::CCOMP_W*i +: bcps_pkg::CCOMP_W]))
                      - OPW'(p_r[i]);
          end
          acc_r   <= '0;
          cv_r    <= '0;
          k_r     <= '0;
          state_r <= S_SS_M;
        end
        S_SS_M: state_r <= S_SS_A;
        S_SS_A: begin
          acc_r <= acc_sum;
          if (k_last) begin
            k_r     <= '0;
            state_r <= S_SV_M;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SS_M;
          end
        end
        S_SV_M: state_r <= S_SV_A;
        S_SV_A: begin
          cv_r <= cv_r + prod_x;
          if (k_last) begin
            k_r     <= '0;
            state_r <= S_TT_M;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SV_M;
          end
        end
        S_TT_M: state_r <= S_TT_F;
        S_TT_F: begin
          if (shell_go) begin
            hs_r    <= 1'b1;
            shell_r <= 1'b1;
            state_r <= S_SQ;
          end else begin
            state_r <= S_GR_M;
          end
        end
        S_SQ: begin
          if (sq_done) begin
            dist_r  <= sq_root;
            k_r     <= '0;
            state_r <= S_DV_S;
          end
        end
        S_DV_S: state_r <= S_DV_W;
        S_DV_W: begin
          if (div_done) begin
            nv_r[k_r] <= c_r[k_r][OPW-1] ? -q_s : q_s;
            if (k_last) begin
              e_r     <= OPW'($signed(ACC_W'(dist_r)) - sr_x);
              k_r     <= '0;
              state_r <= S_PP_M;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_DV_S;
            end
          end
        end
        S_GR_M: state_r <= S_GR_A;
        S_GR_A: begin
          v_r[2] <= clampv(vg_val);
          if (ovf(vg_val)) sat_r <= 1'b1;
          k_r     <= '0;
          state_r <= S_PI_M;
        end
        S_PI_M: state_r <= S_PI_A;
        S_PI_A: begin
          p_r[k_r] <= clampv(pi_sum);
          if (ovf(pi_sum)) sat_r <= 1'b1;
          if (k_last) begin
            k_r     <= '0;
            state_r <= S_DONE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PI_M;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              po_r[i] <= p_r[i];
              vo_r[i] <= v_r[i];
            end
            hp_o_r  <= hp_r;
            hs_o_r  <= hs_r;
            sat_o_r <= sat_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BCPS_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)
  `BCPS_ASSERT_IMP(a_root_when_waiting, clk, rst_n, sq_done, state_r == S_SQ)
  `BCPS_ASSERT_IMP(a_quo_when_waiting, clk, rst_n, div_done, state_r == S_DV_W)
  `BCPS_ASSERT_NXT(a_result_issued, clk, rst_n,
                   (state_r == S_DONE) && !(out_valid_r && out_stall),
                   out_valid_r && (state_r == S_IDLE))
endmodule
